@@ rtl/rdq_pkg.sv @@
package rdq_pkg;

   localparam int CAPACITY   = 1024;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND   = 3'd0,
      OP_PREPEND  = 3'd1,
      OP_READ     = 3'd2,
      OP_REVERSE  = 3'd3,
      OP_CLEAR    = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_FULL         = 2'd1,
      ST_OUT_OF_RANGE = 2'd2
   } status_type;

   // Result of one transaction, waiting for the read data of the memory.
   typedef struct packed {
      logic                  rd_ok;
      logic [STATUS_W-1:0]   status;
      logic [COUNT_W-1:0]    count;
   } meta_type;

   // Physical slot of a storage position: (head + pos) mod CAPACITY.
   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                 input logic [ADDR_W-1:0] pos);
      logic [ADDR_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (ADDR_W+1)'(CAPACITY)) begin
         sum = sum - (ADDR_W+1)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

@@ rtl/rdq_if.sv @@
interface rdq_req_if;
   import rdq_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [VALUE_W-1:0]  value;
   logic [POS_W-1:0]    position;

   modport source (output valid, output opcode, output value, output position,
                   input ready);
   modport sink   (input valid, input opcode, input value, input position,
                   output ready);
endinterface

interface rdq_rsp_if;
   import rdq_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  read_data;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output read_data, output status, output count,
                   input ready);
   modport sink   (input valid, input read_data, input status, input count,
                   output ready);
endinterface

@@ rtl/rdq_ram.sv @@
module rdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rdq_ctrl.sv @@
module rdq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue,
   input  logic [rdq_pkg::OPCODE_W-1:0]    opcode,
   input  logic [rdq_pkg::VALUE_W-1:0]     value,
   input  logic [rdq_pkg::POS_W-1:0]       position,
   output logic                            wr_en,
   output logic [rdq_pkg::ADDR_W-1:0]      wr_addr,
   output logic [rdq_pkg::DATA_WIDTH-1:0]  wr_data,
   output logic                            rd_en,
   output logic [rdq_pkg::ADDR_W-1:0]      rd_addr,
   output rdq_pkg::meta_type               meta
);
   import rdq_pkg::*;

   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              flip_ff, flip_in;

   opcode_type        op;
   logic              full;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic [CMP_W-1:0]  sp_ext;
   logic              in_range;
   status_type        status;
   logic              rd_ok;
   logic              wr_req;

   always_comb begin
      op       = opcode_type'(opcode);
      full     = (count_ff == CNT_W'(CAPACITY));
      pos_ext  = CMP_W'(position);
      cnt_ext  = CMP_W'(count_ff);
      in_range = (pos_ext < cnt_ext);
      sp_ext   = flip_ff ? (cnt_ext - CMP_W'(1) - pos_ext) : pos_ext;

      head_in  = head_ff;
      count_in = count_ff;
      flip_in  = flip_ff;
      status   = ST_OK;
      rd_ok    = 1'b0;
      wr_req   = 1'b0;
      wr_addr  = slot_of(head_ff, count_ff[ADDR_W-1:0]);
      rd_addr  = slot_of(head_ff, sp_ext[ADDR_W-1:0]);

      case (op)
         OP_APPEND, OP_PREPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               wr_req   = 1'b1;
               count_in = count_ff + CNT_W'(1);
               // Logical back is the storage tail unless the order is flipped.
               if ((op == OP_APPEND) != flip_ff) begin
                  wr_addr = slot_of(head_ff, count_ff[ADDR_W-1:0]);
               end else begin
                  head_in = (head_ff == '0) ? ADDR_W'(CAPACITY - 1)
                                            : head_ff - ADDR_W'(1);
                  wr_addr = head_in;
               end
            end
         end
         OP_READ: begin
            if (in_range) begin
               rd_ok = 1'b1;
            end else begin
               status = ST_OUT_OF_RANGE;
            end
         end
         OP_REVERSE: begin
            flip_in = !flip_ff;
         end
         OP_CLEAR: begin
            count_in = '0;
            head_in  = '0;
         end
         default: begin
         end
      endcase
   end

   assign wr_en       = issue && wr_req;
   assign wr_data     = DATA_WIDTH'(value);
   assign rd_en       = issue && rd_ok;
   assign meta.rd_ok  = rd_ok;
   assign meta.status = status;
   assign meta.count  = COUNT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         flip_ff  <= 1'b0;
      end else if (issue) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         flip_ff  <= flip_in;
      end
   end

endmodule

@@ rtl/rdq_out.sv @@
module rdq_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue,
   input  rdq_pkg::meta_type               meta,
   input  logic [rdq_pkg::DATA_WIDTH-1:0]  rd_data,
   output logic                            can_take,
   rdq_rsp_if.source                       rsp
);
   import rdq_pkg::*;

   logic                pend_valid_ff, pend_valid_in;
   meta_type            pend_meta_ff;
   logic                out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]  out_data_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                advance;

   // The memory read data stays put while the pending transaction waits,
   // since no new read is issued until it moves on.
   assign advance  = pend_valid_ff && (!out_valid_ff || rsp.ready);
   assign can_take = !pend_valid_ff || advance;

   always_comb begin
      pend_valid_in = issue ? 1'b1 : (advance ? 1'b0 : pend_valid_ff);
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      if (issue) begin
         pend_meta_ff <= meta;
      end
      if (advance) begin
         out_data_ff   <= pend_meta_ff.rd_ok ? VALUE_W'(rd_data) : '0;
         out_status_ff <= pend_meta_ff.status;
         out_count_ff  <= pend_meta_ff.count;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.read_data = out_data_ff;
   assign rsp.status    = out_status_ff;
   assign rsp.count     = out_count_ff;

endmodule

@@ rtl/reversible_deque_unit.sv @@
// Channel   Port     Direction  Payload
// request   req_if   in         opcode, value, position
// response  rsp_if   out        read_data, status, count
//
// One transaction per cycle sustained while the response side accepts; a result
// passes through the element memory's registered read and then the output
// register. Synchronous active-high reset clears the head pointer, element
// count and order flag; memory contents are not cleared.
// A stalled response holds one pending transaction behind it, then the
// request side is held off.
module reversible_deque_unit (
   input  logic       clock,
   input  logic       reset,
   rdq_req_if.sink    req_if,
   rdq_rsp_if.source  rsp_if
);
   import rdq_pkg::*;

   logic                  issue;
   logic                  can_take;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   meta_type              meta;

   assign req_if.ready = can_take;
   assign issue        = req_if.valid && can_take;

   rdq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .opcode   (req_if.opcode),
      .value    (req_if.value),
      .position (req_if.position),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .meta     (meta)
   );

   rdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rdq_out u_out (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .meta     (meta),
      .rd_data  (rd_data),
      .can_take (can_take),
      .rsp      (rsp_if)
   );

endmodule

@@ verif/rdq_checker.sv @@
module rdq_checker (
   input  logic  clock,
   input  logic  reset,
   rdq_req_if    req_mon,
   rdq_rsp_if    rsp_mon,
   output int    mismatch_count,
   output int    results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rdq_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0] data;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } deque_outcome_type;

   logic [VALUE_W-1:0] words [CAPACITY];
   int                 head;
   int                 fill;
   bit                 flipped;
   deque_outcome_type  expected_results [$];

   // Apply one operation to the shadow deque and return what the block must answer.
   function automatic deque_outcome_type apply_deque_op(input logic [OPCODE_W-1:0] op,
                                                        input logic [VALUE_W-1:0]  val,
                                                        input logic [POS_W-1:0]    pos);
      deque_outcome_type res;
      int                sp;
      res.data   = '0;
      res.status = ST_OK;
      case (op)
         OP_APPEND, OP_PREPEND: begin
            if (fill >= CAPACITY) begin
               res.status = ST_FULL;
            end else if ((op == OP_APPEND) != flipped) begin
               words[(head + fill) % CAPACITY] = val;
               fill++;
            end else begin
               head = (head + CAPACITY - 1) % CAPACITY;
               words[head] = val;
               fill++;
            end
         end
         OP_READ: begin
            if (int'(pos) >= fill) begin
               res.status = ST_OUT_OF_RANGE;
            end else begin
               sp = flipped ? (fill - 1 - int'(pos)) : int'(pos);
               res.data = words[(head + sp) % CAPACITY];
            end
         end
         OP_REVERSE: begin
            flipped = !flipped;
         end
         OP_CLEAR: begin
            // order flag survives a clear
            fill = 0;
            head = 0;
         end
         default: ;
      endcase
      res.count = COUNT_W'(fill);
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      deque_outcome_type want;
      if (reset) begin
         head    = 0;
         fill    = 0;
         flipped = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transaction, expected none, actual %h/%h/%h",
                        $time, rsp_mon.read_data, rsp_mon.status, rsp_mon.count);
            end else begin
               want = expected_results.pop_front();
               check_field("read_data", 32'(want.data), 32'(rsp_mon.read_data));
               check_field("status", 32'(want.status), 32'(rsp_mon.status));
               check_field("count", 32'(want.count), 32'(rsp_mon.count));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.insert(expected_results.size(),
                                    apply_deque_op(req_mon.opcode, req_mon.value,
                                                   req_mon.position));
         end
      end
      results_pending = expected_results.size();
   end

endmodule

@@ verif/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rdq_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int HOLD_OFF_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid    = 1'b0;
   logic [OPCODE_W-1:0] req_opcode   = '0;
   logic [VALUE_W-1:0]  req_value    = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_ready    = 1'b0;

   int  req_idle      = 0;
   int  rsp_idle      = 0;
   int  depth_guess   = 0;
   int  items_sent    = 0;
   bit  hold_off_req  = 1'b0;
   bit  hold_off_done = 1'b0;
   int  stall_left    = 0;
   int  mismatch_count;
   int  results_pending;

   rdq_req_if req_if ();
   rdq_rsp_if rsp_if ();

   assign req_if.valid    = req_valid;
   assign req_if.opcode   = req_opcode;
   assign req_if.value    = req_value;
   assign req_if.position = req_position;
   assign rsp_if.ready    = rsp_ready;

   reversible_deque_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   rdq_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Receiver: random stalls, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (hold_off_req && !hold_off_done) begin
         rsp_ready     <= 1'b0;
         stall_left    <= HOLD_OFF_CYCLES;
         hold_off_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle);
      end
   end

   task automatic send(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                       input logic [POS_W-1:0] pos);
      while ($urandom_range(0, 99) < req_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_value    <= val;
      req_position <= pos;
      do @(posedge clock); while (!req_if.ready);
      if (op == OP_APPEND || op == OP_PREPEND) begin
         if (depth_guess < CAPACITY) depth_guess++;
      end else if (op == OP_CLEAR) begin
         depth_guess = 0;
      end
      if (op <= OP_CLEAR) items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (results_pending == 0);
   endtask

   function automatic logic [OPCODE_W-1:0] any_push();
      return $urandom_range(0, 1) ? OP_PREPEND : OP_APPEND;
   endfunction

   function automatic logic [POS_W-1:0] held_pos();
      if (depth_guess == 0) return POS_W'($urandom);
      return POS_W'($urandom_range(0, depth_guess - 1));
   endfunction

   function automatic logic [POS_W-1:0] beyond_pos();
      if (depth_guess >= CAPACITY) return POS_W'($urandom);
      return POS_W'($urandom_range(depth_guess, CAPACITY - 1));
   endfunction

   task automatic random_burst();
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 10);
      if (kind < 40) begin
         repeat (len) send(any_push(), $urandom, POS_W'($urandom));
      end else if (kind < 70) begin
         repeat (len) send(OP_READ, $urandom, held_pos());
      end else if (kind < 78) begin
         send(OP_READ, $urandom, beyond_pos());
      end else if (kind < 86) begin
         send(OP_REVERSE, $urandom, POS_W'($urandom));
      end else if (kind < 90) begin
         send(OP_CLEAR, $urandom, POS_W'($urandom));
      end else if (kind < 95) begin
         send(OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), $urandom,
              POS_W'($urandom));
      end else begin
         send(OPCODE_W'($urandom_range(0, 7)), $urandom, POS_W'($urandom));
      end
   endtask

   task automatic random_phase(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) random_burst();
   endtask

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty read, extremes of the word, both ends, reverse, spare codes
      send(OP_READ, '0, '0);
      send(OP_APPEND, 32'h0000_0000, '0);
      send(OP_APPEND, 32'hFFFF_FFFF, '1);
      send(OP_PREPEND, 32'h5A5A_5A5A, '0);
      send(OP_PREPEND, 32'hA5A5_A5A5, '0);
      for (int i = 0; i < 4; i++) send(OP_READ, '0, POS_W'(i));
      send(OP_READ, '0, POS_W'(4));
      send(OP_READ, '0, '1);
      send(OP_REVERSE, '0, '0);
      send(OP_READ, '0, POS_W'(0));
      send(OP_READ, '0, POS_W'(3));
      send(OP_APPEND, 32'h1234_5678, '0);
      send(OP_PREPEND, 32'h8765_4321, '0);
      send(OP_READ, '0, POS_W'(0));
      send(OP_READ, '0, POS_W'(5));
      send(OP_SPARE_FIRST, '1, '1);
      send(OP_SPARE_FIRST + 3'd1, '1, '1);
      send(OP_SPARE_LAST, '1, '1);
      send(OP_CLEAR, '1, '1);
      send(OP_READ, '0, '0);
      send(OP_APPEND, 32'hDEAD_BEEF, '0);
      send(OP_REVERSE, '0, '0);

      req_idle = 24;
      rsp_idle = 88;
      random_phase(130);
      drain();

      req_idle = 88;
      rsp_idle = 24;
      random_phase(130);
      drain();

      // fill to capacity behind a long receiver hold-off
      req_idle = 0;
      rsp_idle = 0;
      send(OP_CLEAR, $urandom, POS_W'($urandom));
      hold_off_req = 1'b1;
      while (depth_guess < CAPACITY) send(any_push(), $urandom, POS_W'($urandom));
      send(OP_APPEND, $urandom, '0);
      send(OP_PREPEND, $urandom, '0);
      send(OP_READ, '0, '0);
      send(OP_READ, '0, '1);
      send(OP_REVERSE, '0, '0);
      send(OP_READ, '0, '1);
      send(OP_READ, '0, '0);
      repeat (8) send(OP_READ, $urandom, POS_W'($urandom));
      send(any_push(), $urandom, '0);
      send(OP_CLEAR, $urandom, POS_W'($urandom));

      random_phase(110);

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
